@@ rtl/cts_pkg.sv @@
// shared types, codes and arithmetic helpers of the complex triangular solver
package cts_pkg;

  localparam int IDX_W = 6;
  localparam int DW    = 32;
  localparam int QW    = 34;
  localparam int NUM_W = 96;

  localparam logic [1:0] KIND_MAT   = 2'd0;
  localparam logic [1:0] KIND_RHS   = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam logic [1:0] MODE_UPPER = 2'd0;
  localparam logic [1:0] MODE_CONJ  = 2'd1;

  localparam logic [2:0] REG_SIZE     = 3'd0;
  localparam logic [2:0] REG_COLUMNS  = 3'd1;
  localparam logic [2:0] REG_MODE     = 3'd2;
  localparam logic [2:0] REG_ALPHA_RE = 3'd3;
  localparam logic [2:0] REG_ALPHA_IM = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MODE  = 2'd1;
  localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

  typedef enum logic [1:0] {MAC_ADD, MAC_SUB, MAC_SUBC, MAC_SQ} mac_op_t;
  typedef enum logic [1:0] {A_ALPHA, A_MAT, A_T} a_sel_t;
  typedef enum logic [1:0] {B_RHS, B_REC, B_MAT} b_sel_t;

  typedef struct packed {
    logic             mat_rd;
    logic [IDX_W-1:0] mat_row;
    logic [IDX_W-1:0] mat_col;
    logic             rhs_rd;
    logic             rhs_wr;
    logic [IDX_W-1:0] rhs_row;
    logic [IDX_W-1:0] rhs_col;
    logic             mac_en;
    mac_op_t          mac_op;
    a_sel_t           a_sel;
    b_sel_t           b_sel;
    logic [1:0]       part;
    logic             acc_clear;
    logic             acc_sat;
    logic             t_load;
    logic             d_clear;
    logic             rec_clear;
    logic             rec_re_load;
    logic             rec_im_load;
    logic             div_start;
    logic             div_im;
    logic             out_load;
    logic             out_zero;
    logic [1:0]       out_status;
    logic             out_last;
  } cts_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
  } cts_stat_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
    logic signed [DW-1:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[DW-1:0];
    return r;
  endfunction

  function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
    logic [DW-1:0] r;
    r = v[DW-1] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  // clamp a reciprocal quotient and apply its sign
  function automatic logic signed [DW-1:0] quot_fix(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0]        qc;
    logic signed [DW-1:0] r;
    qc = (q > 34'h080000000) ? 34'h080000000 : q;
    if (neg) r = -$signed(qc[DW-1:0]);
    else if (qc == 34'h080000000) r = 32'sh7fffffff;
    else r = $signed(qc[DW-1:0]);
    return r;
  endfunction

endpackage

@@ rtl/cts_div.sv @@
// restoring divider, one quotient bit per cycle, for the diagonal reciprocals
module cts_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cts_pkg::NUM_W-1:0] num,
  input  logic [63:0]               den,
  output logic                      done,
  output logic [cts_pkg::QW-1:0]    q
);
  import cts_pkg::*;

  logic [63:0]   rem;
  logic [QW-1:0] nsh;
  logic [5:0]    cnt;
  logic          busy;
  logic [64:0]   trial;
  logic [64:0]   diff;
  logic          ge;

  assign trial = {rem, nsh[QW-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {2'b0, num[NUM_W-1:QW]};
      nsh <= num[QW-1:0];
      q   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[63:0] : trial[63:0];
      nsh <= {nsh[QW-2:0], 1'b0};
      q   <= {q[QW-2:0], ge};
    end
  end

endmodule

@@ rtl/cts_dp.sv @@
// datapath: matrix and right-hand stores, shared multiplier, accumulators, reciprocal
module cts_dp #(
  parameter int MAX_ORDER   = 8,
  parameter int MAX_COLUMNS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cts_pkg::cts_cmd_t      cmd,
  output cts_pkg::cts_stat_t     stat,
  input  logic [1:0]             mode,
  input  logic signed [31:0]     alpha_re,
  input  logic signed [31:0]     alpha_im,
  input  logic                   load_mat,
  input  logic                   load_rhs,
  input  logic [2:0]             row,
  input  logic [2:0]             col,
  input  logic signed [31:0]     value_re,
  input  logic signed [31:0]     value_im,
  output logic [2:0]             out_row,
  output logic [2:0]             out_col,
  output logic signed [31:0]     x_re,
  output logic signed [31:0]     x_im,
  output logic [1:0]             status,
  output logic                   last
);
  import cts_pkg::*;

  localparam int MDEPTH = MAX_ORDER * MAX_ORDER;
  localparam int RDEPTH = MAX_ORDER * MAX_COLUMNS;
  localparam int MA_W   = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int RA_W   = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

  logic [63:0] mat_mem [MDEPTH];
  logic [63:0] rhs_mem [RDEPTH];

  logic signed [31:0] mr_re, mr_im, br_re, br_im;
  logic signed [31:0] t_re, t_im, rec_re, rec_im;
  logic signed [31:0] a_re, a_im, b_re, b_im, op_x, op_y;
  logic signed [63:0] prod, rnd, rnd_pre, acc_re, acc_im;
  logic [63:0]        dreg;
  logic               v1, neg1, im1, sq1, v2, neg2, im2;
  logic               neg_term;
  logic [MA_W-1:0]    maddr_rd, maddr_wr;
  logic [RA_W-1:0]    raddr_rd, raddr_wr;
  logic               rhs_we;
  logic [63:0]        rhs_wdata;
  logic [31:0]        ua, ub, ma;
  logic [NUM_W-1:0]   num;
  logic [63:0]        den;
  logic               div_done;
  logic [QW-1:0]      q;
  logic signed [31:0] sat_re, sat_im;

  assign maddr_rd = MA_W'(32'(cmd.mat_row) * MAX_ORDER + 32'(cmd.mat_col));
  assign maddr_wr = MA_W'(32'(row) * MAX_ORDER + 32'(col));
  assign raddr_rd = RA_W'(32'(cmd.rhs_row) * MAX_COLUMNS + 32'(cmd.rhs_col));
  assign raddr_wr = cmd.rhs_wr ? raddr_rd : RA_W'(32'(row) * MAX_COLUMNS + 32'(col));

  assign sat_re    = sat32(acc_re);
  assign sat_im    = sat32(acc_im);
  assign rhs_we    = cmd.rhs_wr || (load_rhs && 32'(row) < MAX_ORDER && 32'(col) < MAX_COLUMNS);
  assign rhs_wdata = cmd.rhs_wr ? {sat_re, sat_im} : {value_re, value_im};

  always_ff @(posedge clk) begin
    if (load_mat && 32'(row) < MAX_ORDER && 32'(col) < MAX_ORDER)
      mat_mem[maddr_wr] <= {value_re, value_im};
    if (cmd.mat_rd)
      {mr_re, mr_im} <= mat_mem[maddr_rd];
  end

  always_ff @(posedge clk) begin
    if (rhs_we)
      rhs_mem[raddr_wr] <= rhs_wdata;
    if (cmd.rhs_rd)
      {br_re, br_im} <= rhs_mem[raddr_rd];
  end

  // operand selection for one real term of a complex product
  always_comb begin
    case (cmd.a_sel)
      A_ALPHA: begin a_re = alpha_re; a_im = alpha_im; end
      A_MAT:   begin a_re = mr_re;    a_im = mr_im;    end
      A_T:     begin a_re = t_re;     a_im = t_im;     end
      default: begin a_re = '0;       a_im = '0;       end
    endcase
    case (cmd.b_sel)
      B_RHS:   begin b_re = br_re;  b_im = br_im;  end
      B_REC:   begin b_re = rec_re; b_im = rec_im; end
      B_MAT:   begin b_re = mr_re;  b_im = mr_im;  end
      default: begin b_re = '0;     b_im = '0;     end
    endcase
    op_x = (cmd.part == 2'd0 || cmd.part == 2'd2) ? a_re : a_im;
    op_y = (cmd.part == 2'd0 || cmd.part == 2'd3) ? b_re : b_im;
    case (cmd.mac_op)
      MAC_ADD:  neg_term = (cmd.part == 2'd1);
      MAC_SUB:  neg_term = (cmd.part != 2'd1);
      MAC_SUBC: neg_term = (cmd.part != 2'd3);
      default:  neg_term = 1'b0;
    endcase
  end

  assign rnd_pre = prod + 64'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_en;
      v2 <= v1 && !sq1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_x * op_y;
    neg1 <= neg_term;
    im1  <= cmd.part[1];
    sq1  <= (cmd.mac_op == MAC_SQ);
    rnd  <= rnd_pre >>> 16;
    neg2 <= neg1;
    im2  <= im1;
    if (cmd.d_clear) dreg <= '0;
    else if (v1 && sq1) dreg <= dreg + $unsigned(prod);
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (cmd.acc_sat) begin
      acc_re <= 64'(sat_re);
      acc_im <= 64'(sat_im);
    end else if (cmd.t_load) begin
      t_re   <= sat_re;
      t_im   <= sat_im;
      acc_re <= '0;
      acc_im <= '0;
    end else if (v2) begin
      if (im2) acc_im <= neg2 ? acc_im - rnd : acc_im + rnd;
      else acc_re <= neg2 ? acc_re - rnd : acc_re + rnd;
    end
  end

  // reciprocal of the diagonal
  assign ua = mag32(mr_re);
  assign ub = mag32(mr_im);
  assign ma = cmd.div_im ? ub : ua;

  always_comb begin
    if (mode == MODE_UPPER) begin
      num = {32'b0, ma, 32'b0} + {33'b0, dreg[63:1]};
      den = dreg;
    end else begin
      num = 96'h1_0000_0000 + {65'b0, ua[31:1]};
      den = {32'b0, ua};
    end
  end

  assign stat.den_zero = (den == 64'd0);
  assign stat.div_done = div_done;

  cts_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .q     (q)
  );

  always_ff @(posedge clk) begin
    if (cmd.rec_clear) begin
      rec_re <= '0;
      rec_im <= '0;
    end else if (cmd.rec_re_load) begin
      rec_re <= quot_fix(q, mr_re[31]);
      if (mode != MODE_UPPER) rec_im <= '0;
    end else if (cmd.rec_im_load) begin
      rec_im <= quot_fix(q, !mr_im[31] && mr_im != 32'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row <= 3'(cmd.rhs_row);
      out_col <= 3'(cmd.rhs_col);
      x_re    <= cmd.out_zero ? 32'sd0 : br_re;
      x_im    <= cmd.out_zero ? 32'sd0 : br_im;
      status  <= cmd.out_status;
      last    <= cmd.out_last;
    end
  end

endmodule

@@ rtl/cts_ctrl.sv @@
// controller: sequences reciprocal, dot products, write-back and result transfers
module cts_ctrl #(
  parameter int MAX_ORDER   = 8,
  parameter int MAX_COLUMNS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [$clog2(MAX_ORDER+1)-1:0]         n,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]       c,
  input  logic [1:0]                             mode,
  input  logic                                   alpha_zero,
  input  cts_pkg::cts_stat_t                     stat,
  input  logic                                   out_stall,
  output cts_pkg::cts_cmd_t                      cmd,
  output logic                                   in_stall,
  output logic                                   out_valid
);
  import cts_pkg::*;

  localparam int NW  = $clog2(MAX_ORDER + 1);
  localparam int CNW = $clog2(MAX_COLUMNS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_ROW, S_DIAG_RD, S_SQ, S_REC_CHK, S_WAIT_RE, S_DIV_IM, S_WAIT_IM,
    S_COL_RD, S_T_MAC, S_T_SAT, S_DOT_CHK, S_DOT_RD, S_DOT_MAC, S_F_T, S_F_MAC,
    S_WB, S_OUT_RD, S_OUT_LD, S_OUT_SET, S_OUT_WAIT, S_DRAIN
  } state_t;

  state_t         state, resume;
  logic [NW-1:0]  k, i, m;
  logic [CNW-1:0] j;
  logic [1:0]     p, dcnt;
  logic           bad, fin, upper;

  assign upper    = (mode == MODE_UPPER);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      resume    <= S_IDLE;
      cmd       <= '0;
      out_valid <= 1'b0;
      bad       <= 1'b0;
      fin       <= 1'b0;
      k <= '0; i <= '0; m <= '0; j <= '0; p <= '0; dcnt <= '0;
    end else begin
      cmd <= '0;
      case (state)
        S_IDLE: begin
          if (start) begin
            bad <= 1'b0;
            i   <= '0;
            j   <= '0;
            k   <= '0;
            if (mode != MODE_UPPER && mode != MODE_CONJ) state <= S_ERR;
            else if (alpha_zero) state <= S_OUT_RD;
            else state <= S_ROW;
          end
        end
        S_ERR: begin
          cmd.out_load   <= 1'b1;
          cmd.out_zero   <= 1'b1;
          cmd.out_status <= ST_BAD_MODE;
          cmd.out_last   <= 1'b1;
          fin            <= 1'b1;
          state          <= S_OUT_SET;
        end
        S_ROW: begin
          i     <= upper ? NW'(n - NW'(1) - k) : k;
          state <= S_DIAG_RD;
        end
        S_DIAG_RD: begin
          cmd.mat_rd  <= 1'b1;
          cmd.mat_row <= IDX_W'(i);
          cmd.mat_col <= IDX_W'(i);
          cmd.d_clear <= 1'b1;
          p           <= '0;
          state       <= S_SQ;
        end
        S_SQ: begin
          cmd.mac_en <= 1'b1;
          cmd.mac_op <= MAC_SQ;
          cmd.a_sel  <= A_MAT;
          cmd.b_sel  <= B_MAT;
          cmd.part   <= p;
          p          <= p + 2'd1;
          if (p == 2'd1) begin
            dcnt   <= 2'd2;
            resume <= S_REC_CHK;
            state  <= S_DRAIN;
          end
        end
        S_REC_CHK: begin
          if (stat.den_zero) begin
            bad           <= 1'b1;
            cmd.rec_clear <= 1'b1;
            j             <= '0;
            state         <= S_COL_RD;
          end else begin
            cmd.div_start <= 1'b1;
            state         <= S_WAIT_RE;
          end
        end
        S_WAIT_RE: begin
          if (stat.div_done) begin
            cmd.rec_re_load <= 1'b1;
            j               <= '0;
            state           <= upper ? S_DIV_IM : S_COL_RD;
          end
        end
        S_DIV_IM: begin
          cmd.div_start <= 1'b1;
          cmd.div_im    <= 1'b1;
          state         <= S_WAIT_IM;
        end
        S_WAIT_IM: begin
          cmd.div_im <= 1'b1;
          if (stat.div_done) begin
            cmd.rec_im_load <= 1'b1;
            state           <= S_COL_RD;
          end
        end
        S_COL_RD: begin
          cmd.rhs_rd    <= 1'b1;
          cmd.rhs_row   <= IDX_W'(i);
          cmd.rhs_col   <= IDX_W'(j);
          cmd.acc_clear <= 1'b1;
          p             <= '0;
          state         <= S_T_MAC;
        end
        S_T_MAC: begin
          cmd.mac_en <= 1'b1;
          cmd.mac_op <= MAC_ADD;
          cmd.a_sel  <= A_ALPHA;
          cmd.b_sel  <= B_RHS;
          cmd.part   <= p;
          p          <= p + 2'd1;
          if (p == 2'd3) begin
            dcnt   <= 2'd2;
            resume <= S_T_SAT;
            state  <= S_DRAIN;
          end
        end
        S_T_SAT: begin
          cmd.acc_sat <= 1'b1;
          m           <= upper ? NW'(i + NW'(1)) : '0;
          state       <= S_DOT_CHK;
        end
        S_DOT_CHK: begin
          if (upper ? (m < n) : (m < i)) begin
            state <= S_DOT_RD;
          end else begin
            dcnt   <= 2'd2;
            resume <= S_F_T;
            state  <= S_DRAIN;
          end
        end
        S_DOT_RD: begin
          cmd.mat_rd  <= 1'b1;
          cmd.mat_row <= upper ? IDX_W'(i) : IDX_W'(m);
          cmd.mat_col <= upper ? IDX_W'(m) : IDX_W'(i);
          cmd.rhs_rd  <= 1'b1;
          cmd.rhs_row <= IDX_W'(m);
          cmd.rhs_col <= IDX_W'(j);
          p           <= '0;
          state       <= S_DOT_MAC;
        end
        S_DOT_MAC: begin
          cmd.mac_en <= 1'b1;
          cmd.mac_op <= upper ? MAC_SUB : MAC_SUBC;
          cmd.a_sel  <= A_MAT;
          cmd.b_sel  <= B_RHS;
          cmd.part   <= p;
          p          <= p + 2'd1;
          if (p == 2'd3) begin
            m     <= m + NW'(1);
            state <= S_DOT_CHK;
          end
        end
        S_F_T: begin
          cmd.t_load <= 1'b1;
          p          <= '0;
          state      <= S_F_MAC;
        end
        S_F_MAC: begin
          cmd.mac_en <= 1'b1;
          cmd.mac_op <= MAC_ADD;
          cmd.a_sel  <= A_T;
          cmd.b_sel  <= B_REC;
          cmd.part   <= p;
          p          <= p + 2'd1;
          if (p == 2'd3) begin
            dcnt   <= 2'd2;
            resume <= S_WB;
            state  <= S_DRAIN;
          end
        end
        S_WB: begin
          cmd.rhs_wr  <= 1'b1;
          cmd.rhs_row <= IDX_W'(i);
          cmd.rhs_col <= IDX_W'(j);
          if (CNW'(j + CNW'(1)) < c) begin
            j     <= j + CNW'(1);
            state <= S_COL_RD;
          end else if (NW'(k + NW'(1)) < n) begin
            k     <= k + NW'(1);
            state <= S_ROW;
          end else begin
            i     <= '0;
            j     <= '0;
            state <= S_OUT_RD;
          end
        end
        S_OUT_RD: begin
          cmd.rhs_rd  <= 1'b1;
          cmd.rhs_row <= IDX_W'(i);
          cmd.rhs_col <= IDX_W'(j);
          state       <= S_OUT_LD;
        end
        S_OUT_LD: begin
          cmd.out_load   <= 1'b1;
          cmd.rhs_row    <= IDX_W'(i);
          cmd.rhs_col    <= IDX_W'(j);
          cmd.out_status <= bad ? ST_ZERO_DIAG : ST_OK;
          cmd.out_last   <= (i == NW'(n - NW'(1))) && (j == CNW'(c - CNW'(1)));
          fin            <= (i == NW'(n - NW'(1))) && (j == CNW'(c - CNW'(1)));
          state          <= S_OUT_SET;
        end
        S_OUT_SET: begin
          out_valid <= 1'b1;
          state     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (fin) begin
              fin   <= 1'b0;
              state <= S_IDLE;
            end else begin
              if (CNW'(j + CNW'(1)) < c) begin
                j <= j + CNW'(1);
              end else begin
                j <= '0;
                i <= i + NW'(1);
              end
              state <= S_OUT_RD;
            end
          end
        end
        S_DRAIN: begin
          // wait for the multiply pipeline to empty into the accumulators
          if (dcnt == 2'd0) state <= resume;
          else dcnt <= dcnt - 2'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/complex_triangular_solve.sv @@
// Complex triangular solver, Q16.16. Load items (kind 0 matrix entry, kind 1 right-hand
// entry) are taken one per cycle while the solver is idle and give no result. A start
// item holds the input stalled for the whole solve. Each row first takes the diagonal
// reciprocal: two 34-step bit-serial divides in mode 0, one divide in mode 1, none when
// the diagonal is zero. Each column of the row then runs its dot product on one shared
// 32x32 multiplier. Each result is then held for as long as the output stalls. An invalid
// mode gives one error result; a zero alpha skips the solve and streams the right-hand
// block out unchanged.
module complex_triangular_solve #(
  parameter int MAX_ORDER   = 8,
  parameter int MAX_COLUMNS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [2:0]         row,
  input  logic [2:0]         col,
  input  logic signed [31:0] value_re,
  input  logic signed [31:0] value_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_row,
  output logic [2:0]         out_col,
  output logic signed [31:0] x_re,
  output logic signed [31:0] x_im,
  output logic [1:0]         status,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import cts_pkg::*;

  localparam int NW  = $clog2(MAX_ORDER + 1);
  localparam int CNW = $clog2(MAX_COLUMNS + 1);

  logic [3:0]         size_used, columns_used;
  logic [1:0]         mode;
  logic signed [31:0] alpha_re, alpha_im;
  logic [NW-1:0]      n;
  logic [CNW-1:0]     c;
  logic               in_xfer, start, load_mat, load_rhs;
  cts_cmd_t           cmd;
  cts_stat_t          stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_used    <= 4'd8;
      columns_used <= 4'd1;
      mode         <= MODE_UPPER;
      alpha_re     <= 32'sd65536;
      alpha_im     <= 32'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE:     size_used    <= cfg_data[3:0];
        REG_COLUMNS:  columns_used <= cfg_data[3:0];
        REG_MODE:     mode         <= cfg_data[1:0];
        REG_ALPHA_RE: alpha_re     <= $signed(cfg_data);
        REG_ALPHA_IM: alpha_im     <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // counts of zero become one, counts beyond the store clamp to its size
  assign n = (size_used == 4'd0) ? NW'(1) :
             (32'(size_used) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(size_used);
  assign c = (columns_used == 4'd0) ? CNW'(1) :
             (32'(columns_used) > MAX_COLUMNS) ? CNW'(MAX_COLUMNS) : CNW'(columns_used);

  assign in_xfer  = in_valid && !in_stall;
  assign start    = in_xfer && (kind == KIND_START);
  assign load_mat = in_xfer && (kind == KIND_MAT);
  assign load_rhs = in_xfer && (kind == KIND_RHS);

  cts_ctrl #(
    .MAX_ORDER   (MAX_ORDER),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .n          (n),
    .c          (c),
    .mode       (mode),
    .alpha_zero (alpha_re == 32'sd0 && alpha_im == 32'sd0),
    .stat       (stat),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .in_stall   (in_stall),
    .out_valid  (out_valid)
  );

  cts_dp #(
    .MAX_ORDER   (MAX_ORDER),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .mode     (mode),
    .alpha_re (alpha_re),
    .alpha_im (alpha_im),
    .load_mat (load_mat),
    .load_rhs (load_rhs),
    .row      (row),
    .col      (col),
    .value_re (value_re),
    .value_im (value_im),
    .out_row  (out_row),
    .out_col  (out_col),
    .x_re     (x_re),
    .x_im     (x_im),
    .status   (status),
    .last     (last)
  );

endmodule

@@ rtl/cts_checker.sv @@
// port-level checks of the solver, bound to the top level
module cts_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         kind,
  input logic [2:0]         row,
  input logic [2:0]         col,
  input logic signed [31:0] value_re,
  input logic signed [31:0] value_im,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_row,
  input logic [2:0]         out_col,
  input logic signed [31:0] x_re,
  input logic signed [31:0] x_im,
  input logic [1:0]         status,
  input logic               last,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [31:0]        cfg_data
);
  import cts_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(x_re) && $stable(x_im)
      && $stable(status) && $stable(last) && $stable(out_row) && $stable(out_col))
    else $error("stalled result changed");

  // no new item is taken while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_bad_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD_MODE |-> last && x_re == 32'sd0 && x_im == 32'sd0
      && out_row == 3'd0 && out_col == 3'd0)
    else $error("malformed invalid-mode result");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind complex_triangular_solve cts_checker u_cts_checker (.*);
